### sv/lasc_pkg.sv
// Shared types and constants for the linear axis scan controller.
`timescale 1ns / 1ps
package lasc_pkg;

    localparam int OP_W    = 4;
    localparam int PLACE_W = 16;
    localparam int POS_W   = 16;
    localparam int RAIL_W  = 16;
    localparam int STEP_W  = 12;
    localparam int TOL_W   = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [RAIL_W-1:0] RAIL_RST = 16'd4500;
    localparam logic [STEP_W-1:0] STEP_RST = 12'd20;
    localparam logic [TOL_W-1:0]  TOL_RST  = 16'd1;

    typedef enum logic [OP_W-1:0] {
        OP_TICK      = 4'd0,
        OP_LEFT      = 4'd1,
        OP_RIGHT     = 4'd2,
        OP_STOP      = 4'd3,
        OP_HOME      = 4'd4,
        OP_END       = 4'd5,
        OP_AUTO_ON   = 4'd6,
        OP_AUTO_OFF  = 4'd7,
        OP_TOGGLE    = 4'd8,
        OP_PLACE     = 4'd9
    } t_op;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_HOME  = 2'd1,
        PH_RIGHT = 2'd2,
        PH_LEFT  = 2'd3
    } t_phase;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RAIL = 2'd0,
        REG_STEP = 2'd1,
        REG_TOL  = 2'd2
    } t_cfg_reg;

endpackage

### sv/lasc_req_if.sv
// Command/tick channel carrying one operation beat.
`timescale 1ns / 1ps
interface lasc_req_if import lasc_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    operation;
    logic [PLACE_W-1:0] place_position;

    modport source (output valid, output operation, output place_position, input ready);
    modport sink   (input valid, input operation, input place_position, output ready);
endinterface

### sv/lasc_rsp_if.sv
// Result channel carrying the axis status after each beat.
`timescale 1ns / 1ps
interface lasc_rsp_if import lasc_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [POS_W-1:0] position;
    logic             moving;
    logic             at_home;
    logic             auto_active;

    modport source (output valid, output position, output moving, output at_home,
                     output auto_active, input ready);
    modport sink   (input valid, input position, input moving, input at_home,
                    input auto_active, output ready);
endinterface

### sv/linear_axis_scan_controller_unit.sv
// Linear axis position model: tick/command stage feeding a registered status output.
//
//   channel   dir  handshake            payload
//   i_req     in   valid/ready          operation, place_position
//   o_rsp     out  valid/ready          position, moving, at_home, auto_active
//   i_cfg_*   in   write enable only    index, wdata
//
// Each beat passes through the input register and then the result register; one beat
// per cycle is sustained while the result is accepted. The state update is a single
// add-or-subtract, clamp and compare stage between those registers.
// Synchronous reset clears state and loads the default configuration.
// A stalled result holds the update stage; the input register then fills and drops ready.
`timescale 1ns / 1ps
module linear_axis_scan_controller_unit import lasc_pkg::*; #(
    parameter int POSITION_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    lasc_req_if.sink              i_req,
    lasc_rsp_if.source            o_rsp
);

    localparam int CW = ((POSITION_BITS > POS_W) ? POSITION_BITS : POS_W) + 1;
    localparam logic [CW-1:0] POS_MAX = CW'((64'd1 << POSITION_BITS) - 64'd1);

    logic [RAIL_W-1:0]        r_rail;
    logic [STEP_W-1:0]        r_step;
    logic [TOL_W-1:0]         r_tol;

    logic                     r_in_valid;
    t_op                      r_op;
    logic [PLACE_W-1:0]       r_place;

    logic [POSITION_BITS-1:0] r_pos;
    logic                     r_left;
    logic                     r_right;
    logic                     r_home;
    logic                     r_sweep;
    t_phase                   r_phase;

    logic [POSITION_BITS-1:0] n_pos;
    logic                     n_left;
    logic                     n_right;
    logic                     n_home;
    logic                     n_sweep;
    t_phase                   n_phase;

    logic                     r_out_valid;
    logic [POS_W-1:0]         r_out_pos;
    logic                     r_out_moving;
    logic                     r_out_home;
    logic                     r_out_auto;
    logic [POS_W-1:0]         n_out_pos;
    logic                     n_out_moving;

    logic                     w_in_fire;
    logic                     w_out_free;
    logic                     w_exec;
    logic [CW-1:0]            w_lim;
    logic [CW-1:0]            w_step;
    logic [CW-1:0]            w_rail;
    logic [CW-1:0]            w_pos_e;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rail <= RAIL_RST;
            r_step <= STEP_RST;
            r_tol  <= TOL_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_RAIL: r_rail <= i_cfg_wdata;
                REG_STEP: r_step <= i_cfg_wdata[STEP_W-1:0];
                REG_TOL:  r_tol  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign w_out_free  = !r_out_valid || o_rsp.ready;
    assign w_exec      = r_in_valid && w_out_free;
    assign i_req.ready = !r_in_valid || w_exec;
    assign w_in_fire   = i_req.valid && i_req.ready;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= w_in_fire || (r_in_valid && !w_exec);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_op    <= t_op'(i_req.operation);
            r_place <= i_req.place_position;
        end
    end

    assign w_step = CW'(r_step);
    assign w_rail = CW'(r_rail);
    assign w_lim  = (w_rail > POS_MAX) ? POS_MAX : w_rail;

    // next state
    always_comb begin
        logic [CW-1:0] p;
        logic          gl;
        logic          gr;
        logic          hf;
        logic          sw;
        t_phase        ph;
        logic          do_on;
        logic          do_off;

        p      = CW'(r_pos);
        gl     = r_left;
        gr     = r_right;
        hf     = r_home;
        sw     = r_sweep;
        ph     = r_phase;
        do_on  = 1'b0;
        do_off = 1'b0;

        unique case (r_op)
            OP_TICK: begin
                if (gl) begin
                    if (p <= w_step) begin
                        p  = '0;
                        gl = 1'b0;
                        hf = 1'b1;
                    end else begin
                        p = p - w_step;
                    end
                end
                if (gr) begin
                    if (p + w_step >= w_lim) begin
                        p  = w_lim;
                        gr = 1'b0;
                    end else begin
                        p = p + w_step;
                    end
                end
                if (sw) begin
                    priority if ((ph == PH_HOME || ph == PH_LEFT) && !gl) begin
                        gr = 1'b1;
                        gl = 1'b0;
                        hf = 1'b0;
                        ph = PH_RIGHT;
                    end else if (ph == PH_RIGHT && !gr) begin
                        gl = 1'b1;
                        gr = 1'b0;
                        ph = PH_LEFT;
                    end else begin
                    end
                end
            end
            OP_LEFT, OP_HOME: begin
                gl = 1'b1;
                gr = 1'b0;
            end
            OP_RIGHT: begin
                gr = 1'b1;
                gl = 1'b0;
                hf = 1'b0;
            end
            OP_STOP: begin
                gl = 1'b0;
                gr = 1'b0;
            end
            OP_END: begin
                gr = 1'b1;
                gl = 1'b0;
            end
            OP_AUTO_ON:  do_on  = 1'b1;
            OP_AUTO_OFF: do_off = 1'b1;
            OP_TOGGLE: begin
                do_off = sw;
                do_on  = !sw;
            end
            OP_PLACE: begin
                p  = (CW'(r_place) > w_lim) ? w_lim : CW'(r_place);
                hf = 1'b0;
            end
            default: ;
        endcase

        if (do_on) begin
            sw = 1'b1;
            if (p <= CW'(r_tol)) begin
                p  = '0;
                gr = 1'b1;
                gl = 1'b0;
                hf = 1'b0;
                ph = PH_RIGHT;
            end else begin
                gl = 1'b1;
                gr = 1'b0;
                ph = PH_HOME;
            end
        end
        if (do_off) begin
            sw = 1'b0;
            ph = PH_IDLE;
            gl = 1'b0;
            gr = 1'b0;
        end

        w_pos_e = p;
        n_pos   = p[POSITION_BITS-1:0];
        n_left  = gl;
        n_right = gr;
        n_home  = hf;
        n_sweep = sw;
        n_phase = ph;
    end

    // result fields
    always_comb begin
        n_out_pos    = POS_W'(w_pos_e);
        n_out_moving = n_left || n_right;
    end

    // axis state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_left      <= 1'b0;
            r_right     <= 1'b0;
            r_home      <= 1'b0;
            r_sweep     <= 1'b0;
            r_phase     <= PH_IDLE;
            r_out_valid <= 1'b0;
        end else if (w_exec) begin
            r_pos       <= n_pos;
            r_left      <= n_left;
            r_right     <= n_right;
            r_home      <= n_home;
            r_sweep     <= n_sweep;
            r_phase     <= n_phase;
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_exec) begin
            r_out_pos    <= n_out_pos;
            r_out_moving <= n_out_moving;
            r_out_home   <= n_home;
            r_out_auto   <= n_sweep;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.position    = r_out_pos;
    assign o_rsp.moving      = r_out_moving;
    assign o_rsp.at_home     = r_out_home;
    assign o_rsp.auto_active = r_out_auto;

endmodule
